// ----- rtl/conv3x3_scaled_stream_macros.svh -----
// assertion macros for the conv3x3 scaled stream checker
`ifndef CONV3X3_SCALED_STREAM_MACROS_SVH
`define CONV3X3_SCALED_STREAM_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define C3S_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c3s assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define C3S_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c3s assertion failed");

`endif

// ----- rtl/c3s_pkg.sv -----
// shared constants, types and helpers of the conv3x3 scaled stream
package c3s_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int PIX_W   = 16;
  localparam int DIM_W   = 11;
  localparam int COEF_W  = 48;
  localparam int SCALE_W = 16;
  localparam int RES_W   = 50;
  localparam int IDX_W   = 20;

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int TOT_W = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int CNT_W = $clog2(MAX_COLS * MAX_ROWS + 2 * MAX_COLS + 2);

  // history depth covers the widest window behind the oldest queued item plus a
  // whole frame lead and the queued items that the front may run ahead
  localparam int HIST_AW = $clog2(4 * MAX_COLS + 16);

  localparam int MQ_AW    = 2;
  localparam int MQ_DEPTH = 1 << MQ_AW;
  localparam int OQ_AW    = 1;
  localparam int OQ_DEPTH = 1 << OQ_AW;

  localparam int ACC_W    = 36;
  localparam int TAPS     = 9;
  localparam int MEM_TAPS = 6;
  localparam int TAP_W    = $clog2(TAPS + 1);
  localparam int PROD_W   = 2 * PIX_W;
  localparam int SCL_W    = ACC_W + SCALE_W;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_COLS        = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ROWS        = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEF_TOP    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEF_MID    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_COEF_BOTTOM = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SCALE       = 3'd5;

  function automatic logic [CW-1:0] clamp_cols(input logic [DIM_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > MAX_COLS) begin
      r = CW'(MAX_COLS);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] clamp_rows(input logic [DIM_W-1:0] v);
    logic [RW-1:0] r;
    if (v == '0) begin
      r = RW'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = RW'(MAX_ROWS);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  localparam logic [DIM_W-1:0] RST_DIM = DIM_W'(1024);
  localparam logic [CW-1:0]    RST_C   = clamp_cols(RST_DIM);
  localparam logic [RW-1:0]    RST_R   = clamp_rows(RST_DIM);
  localparam logic [TOT_W-1:0] RST_TOT = TOT_W'(int'(RST_C) * int'(RST_R));
  localparam logic [CNT_W-1:0] RST_END = CNT_W'(2 * int'(RST_C) + 1 + int'(RST_TOT));

  typedef struct packed {
    logic [CW-1:0]             c;
    logic [CNT_W-1:0]          lead;
    logic [CNT_W-1:0]          end_n;
    logic [COEF_W-1:0]         coef_top;
    logic [COEF_W-1:0]         coef_mid;
    logic [COEF_W-1:0]         coef_bot;
    logic signed [SCALE_W-1:0] scale;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [HIST_AW-1:0]  addr;
    logic [PIX_W-1:0]    data;
  } hist_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               last;
    logic [HIST_AW-1:0] wp;
    logic [PIX_W-1:0]   pix0;
    logic [PIX_W-1:0]   pix1;
    logic [PIX_W-1:0]   pix2;
  } mid_item_t;

  typedef struct packed {
    logic [RES_W-1:0] result;
    logic [IDX_W-1:0] idx;
    logic             last;
  } out_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_OUT
  } back_state_t;

endpackage

// ----- rtl/c3s_cfg.sv -----
// configuration registers and derived frame geometry
module c3s_cfg
  import c3s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [COEF_W-1:0] cfg_data,
  output cfg_t              cfg
);

  logic [CW-1:0]             c_eff;
  logic [RW-1:0]             r_eff;
  logic [COEF_W-1:0]         coef_top;
  logic [COEF_W-1:0]         coef_mid;
  logic [COEF_W-1:0]         coef_bot;
  logic signed [SCALE_W-1:0] scale;
  logic [TOT_W-1:0]          total;
  logic [CNT_W-1:0]          end_n;
  logic [CW+RW-1:0]          dim_prod;
  logic [CNT_W-1:0]          lead;

  assign dim_prod = (CW+RW)'(c_eff) * (CW+RW)'(r_eff);
  assign lead     = CNT_W'({c_eff, 1'b0}) + CNT_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_eff    <= RST_C;
      r_eff    <= RST_R;
      coef_top <= '0;
      coef_mid <= '0;
      coef_bot <= '0;
      scale    <= SCALE_W'(1);
      total    <= RST_TOT;
      end_n    <= RST_END;
    end else begin
      total <= TOT_W'(dim_prod);
      end_n <= lead + CNT_W'(total) - CNT_W'(1);
      if (cfg_we) begin
        case (cfg_addr)
          REG_COLS:        c_eff    <= clamp_cols(cfg_data[DIM_W-1:0]);
          REG_ROWS:        r_eff    <= clamp_rows(cfg_data[DIM_W-1:0]);
          REG_COEF_TOP:    coef_top <= cfg_data;
          REG_COEF_MID:    coef_mid <= cfg_data;
          REG_COEF_BOTTOM: coef_bot <= cfg_data;
          REG_SCALE:       scale    <= cfg_data[SCALE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg.c        = c_eff;
  assign cfg.lead     = lead;
  assign cfg.end_n    = end_n;
  assign cfg.coef_top = coef_top;
  assign cfg.coef_mid = coef_mid;
  assign cfg.coef_bot = coef_bot;
  assign cfg.scale    = scale;

endmodule

// ----- rtl/c3s_front.sv -----
// input side: frame counter, item classification, history write and work queue
module c3s_front
  import c3s_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             push,
  input  logic [PIX_W-1:0] pixel,
  output logic             full,
  output hist_wr_t         hist_wr,
  output mid_item_t        mid_head,
  output logic             mid_empty,
  input  logic             mid_pop
);

  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_next;
  logic [HIST_AW-1:0] wp;
  logic [HIST_AW-1:0] wp_next;
  logic [PIX_W-1:0]   prev1;
  logic [PIX_W-1:0]   prev2;
  mid_item_t          mq [MQ_DEPTH];
  logic [MQ_AW-1:0]   mq_rd;
  logic [MQ_AW-1:0]   mq_wr;
  logic [MQ_AW:0]     mq_cnt;
  logic [MQ_AW:0]     mq_cnt_next;
  logic               accept;
  logic               below_lead;
  logic               past_end;
  logic               is_last;
  logic               emit;
  logic               do_pop;
  logic [CNT_W-1:0]   p;
  mid_item_t          mid_in;

  assign full       = (mq_cnt == (MQ_AW+1)'(MQ_DEPTH));
  assign mid_empty  = (mq_cnt == '0);
  assign accept     = push && !full;
  assign wp_next    = wp + HIST_AW'(1);
  assign below_lead = (n < cfg.lead);
  assign past_end   = (n > cfg.end_n);
  assign is_last    = (n == cfg.end_n);
  assign emit       = accept && !below_lead && !past_end;
  assign do_pop     = mid_pop && !mid_empty;
  assign p          = n - cfg.lead;

  always_comb begin
    if (!accept) begin
      n_next = n;
    end else if (below_lead) begin
      n_next = n + CNT_W'(1);
    end else if (past_end || is_last) begin
      n_next = '0;
    end else begin
      n_next = n + CNT_W'(1);
    end
  end

  always_comb begin
    mid_in.idx  = IDX_W'(p);
    mid_in.last = is_last;
    mid_in.wp   = wp_next;
    mid_in.pix0 = pixel;
    mid_in.pix1 = prev1;
    mid_in.pix2 = prev2;
  end

  always_comb begin
    mq_cnt_next = mq_cnt;
    if (emit && !do_pop) begin
      mq_cnt_next = mq_cnt + (MQ_AW+1)'(1);
    end else if (!emit && do_pop) begin
      mq_cnt_next = mq_cnt - (MQ_AW+1)'(1);
    end
  end

  assign hist_wr.en   = accept;
  assign hist_wr.addr = wp_next;
  assign hist_wr.data = pixel;
  assign mid_head     = mq[mq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      wp     <= '0;
      mq_rd  <= '0;
      mq_wr  <= '0;
      mq_cnt <= '0;
    end else begin
      n      <= n_next;
      mq_cnt <= mq_cnt_next;
      if (accept) begin
        wp <= wp_next;
      end
      if (emit) begin
        mq_wr <= mq_wr + MQ_AW'(1);
      end
      if (do_pop) begin
        mq_rd <= mq_rd + MQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev1 <= pixel;
      prev2 <= prev1;
    end
    if (emit) begin
      mq[mq_wr] <= mid_in;
    end
  end

endmodule

// ----- rtl/c3s_back.sv -----
// work side: sample history, multiply-accumulate sequencer, scaling and result queue
module c3s_back
  import c3s_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  hist_wr_t                hist_wr,
  input  mid_item_t               mid_head,
  input  logic                    mid_empty,
  output logic                    mid_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [RES_W-1:0] result,
  output logic [IDX_W-1:0]        out_index,
  output logic                    last
);

  back_state_t               state;
  back_state_t               state_next;
  logic [TAP_W-1:0]          tap;
  logic [TAP_W-1:0]          tap_m;
  mid_item_t                 ent;
  logic signed [ACC_W-1:0]   acc;
  logic [PIX_W-1:0]          hist [1 << HIST_AW];
  logic [PIX_W-1:0]          rd_data;
  logic [HIST_AW-1:0]        rd_back;
  logic [HIST_AW-1:0]        rd_addr;
  logic [HIST_AW-1:0]        c_ext;
  logic                      rd_en;
  logic                      mac_en;
  logic                      oq_push;
  logic                      oq_full;
  logic                      oq_pop;
  logic [PIX_W-1:0]          tap_coef;
  logic [PIX_W-1:0]          sample;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SCL_W-1:0]   scaled;
  out_item_t                 oq [OQ_DEPTH];
  logic [OQ_AW-1:0]          oq_rd;
  logic [OQ_AW-1:0]          oq_wr;
  logic [OQ_AW:0]            oq_cnt;
  logic [OQ_AW:0]            oq_cnt_next;
  out_item_t                 oq_in;
  out_item_t                 oq_head;

  assign oq_full = (oq_cnt == (OQ_AW+1)'(OQ_DEPTH));
  assign empty   = (oq_cnt == '0);
  assign oq_pop  = pop && !empty;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!mid_empty) begin
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        if (tap == TAP_W'(TAPS)) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!oq_full) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mid_pop = 1'b0;
    rd_en   = 1'b0;
    mac_en  = 1'b0;
    oq_push = 1'b0;
    case (state)
      B_IDLE: mid_pop = !mid_empty;
      B_RUN: begin
        rd_en  = (tap < TAP_W'(MEM_TAPS));
        mac_en = (tap != '0);
      end
      B_OUT:  oq_push = !oq_full;
      default: begin
      end
    endcase
  end

  // history taps: kernel row 1 sits cols+2-k back, row 0 sits 2*cols+2-k back
  assign c_ext   = HIST_AW'(cfg.c);
  assign rd_back = (tap < TAP_W'(3)) ? (c_ext + HIST_AW'(2) - HIST_AW'(tap))
                                     : ({c_ext[HIST_AW-2:0], 1'b0} + HIST_AW'(5)
                                        - HIST_AW'(tap));
  assign rd_addr = ent.wp - rd_back;

  assign tap_m = tap - TAP_W'(1);

  always_comb begin
    case (tap_m)
      TAP_W'(0): tap_coef = cfg.coef_mid[0*PIX_W +: PIX_W];
      TAP_W'(1): tap_coef = cfg.coef_mid[1*PIX_W +: PIX_W];
      TAP_W'(2): tap_coef = cfg.coef_mid[2*PIX_W +: PIX_W];
      TAP_W'(3): tap_coef = cfg.coef_top[0*PIX_W +: PIX_W];
      TAP_W'(4): tap_coef = cfg.coef_top[1*PIX_W +: PIX_W];
      TAP_W'(5): tap_coef = cfg.coef_top[2*PIX_W +: PIX_W];
      TAP_W'(6): tap_coef = cfg.coef_bot[0*PIX_W +: PIX_W];
      TAP_W'(7): tap_coef = cfg.coef_bot[1*PIX_W +: PIX_W];
      TAP_W'(8): tap_coef = cfg.coef_bot[2*PIX_W +: PIX_W];
      default:   tap_coef = '0;
    endcase
  end

  always_comb begin
    if (tap_m < TAP_W'(MEM_TAPS)) begin
      sample = rd_data;
    end else if (tap_m == TAP_W'(6)) begin
      sample = ent.pix2;
    end else if (tap_m == TAP_W'(7)) begin
      sample = ent.pix1;
    end else begin
      sample = ent.pix0;
    end
  end

  assign prod   = $signed(tap_coef) * $signed(sample);
  assign scaled = SCL_W'(acc) * SCL_W'(cfg.scale);

  assign oq_in.result = RES_W'(scaled);
  assign oq_in.idx    = ent.idx;
  assign oq_in.last   = ent.last;

  always_comb begin
    oq_cnt_next = oq_cnt;
    if (oq_push && !oq_pop) begin
      oq_cnt_next = oq_cnt + (OQ_AW+1)'(1);
    end else if (!oq_push && oq_pop) begin
      oq_cnt_next = oq_cnt - (OQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      tap    <= '0;
      oq_rd  <= '0;
      oq_wr  <= '0;
      oq_cnt <= '0;
    end else begin
      state  <= state_next;
      oq_cnt <= oq_cnt_next;
      if (state == B_RUN) begin
        tap <= tap + TAP_W'(1);
      end else begin
        tap <= '0;
      end
      if (oq_push) begin
        oq_wr <= oq_wr + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      ent <= mid_head;
      acc <= '0;
    end else if (mac_en) begin
      acc <= acc + ACC_W'(prod);
    end
    if (oq_push) begin
      oq[oq_wr] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_wr.en) begin
      hist[hist_wr.addr] <= hist_wr.data;
    end
    if (rd_en) begin
      rd_data <= hist[rd_addr];
    end
  end

  assign oq_head   = oq[oq_rd];
  assign result    = $signed(oq_head.result);
  assign out_index = oq_head.idx;
  assign last      = oq_head.last;

endmodule

// ----- rtl/conv3x3_scaled_stream.sv -----
// 3x3 convolution over a raster pixel stream, scaled; queue-style ports on both sides.
// Pixels enter at one per cycle whenever full is low. The first 2*cols+2 samples of a
// frame only fill the history and yield nothing; every later sample up to the end of
// the frame yields one result. Such an item passes through the multiply-accumulate engine
// as six history reads, nine multiply-accumulate steps on a single 16x16 multiplier and
// one scaling step; the engine takes no new item until the last has gone to the result
// queue, and a four-entry work queue lets the input side run ahead by that many
// result-bearing items. Column and row writes reach the datapath through the column
// and row registers, then the registered frame size and end count. The sample history
// needs no clearing after reset, so items are taken from the first cycle after reset.
module conv3x3_scaled_stream
  import c3s_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [COEF_W-1:0]       cfg_data,
  input  logic                    push,
  input  logic signed [PIX_W-1:0] pixel,
  output logic                    full,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [RES_W-1:0] result,
  output logic [IDX_W-1:0]        out_index,
  output logic                    last
);

  cfg_t      cfg;
  hist_wr_t  hist_wr;
  mid_item_t mid_head;
  logic      mid_empty;
  logic      mid_pop;

  c3s_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  c3s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .pixel     (pixel),
    .full      (full),
    .hist_wr   (hist_wr),
    .mid_head  (mid_head),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop)
  );

  c3s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .hist_wr   (hist_wr),
    .mid_head  (mid_head),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .out_index (out_index),
    .last      (last)
  );

endmodule

// ----- rtl/c3s_checker.sv -----
// port-level checker for the conv3x3 scaled stream, bound to the top level
`include "conv3x3_scaled_stream_macros.svh"

module c3s_checker
  import c3s_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input logic signed [RES_W-1:0] result,
  input logic [IDX_W-1:0]        out_index,
  input logic                    last
);

  // reset leaves both queues empty
  `C3S_ASSERT_IMPLY(a_reset_clears, $past(rst), empty && !full)

  // after reset, no item reaches the result side before passing the engine
  `C3S_ASSERT_IMPLY(a_no_early_result, $past(rst, 2), empty)

  // a waiting item holds until taken
  `C3S_ASSERT_NEXT(a_result_holds, !empty && !pop,
    !empty && $stable(result) && $stable(out_index) && $stable(last))

endmodule

bind conv3x3_scaled_stream c3s_checker u_c3s_checker (.*);

// ----- tb/sv/tb_conv3x3_scaled_stream.sv -----
// self-checking testbench for the 3x3 scaled convolution stream, with its own window predictor
module tb_conv3x3_scaled_stream;
  import c3s_pkg::*;

  localparam int LINE_DEPTH = 2 * MAX_COLS + 3;
  localparam int TOTAL_ITEMS = 1850;
  localparam int WIDE_COLS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [CFG_AW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic signed [PIX_W-1:0] pixel = '0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  logic signed [RES_W-1:0] result;
  logic [IDX_W-1:0] out_index;
  logic last;

  conv3x3_scaled_stream dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .push(push), .pixel(pixel), .full(full),
    .empty(empty), .pop(pop),
    .result(result), .out_index(out_index), .last(last)
  );

  always #4 clk = ~clk;

  // predictor state and register copy
  logic [DIM_W-1:0] cols_reg;
  logic [DIM_W-1:0] rows_reg;
  logic [COEF_W-1:0] taps [3];
  logic signed [SCALE_W-1:0] gain;
  logic signed [PIX_W-1:0] line_buf [LINE_DEPTH];
  int line_wr;
  longint frame_count;

  logic signed [PIX_W-1:0] pending_pixels [$];
  out_item_t conv_results [$];

  int unsigned pixels_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned hold_asks = 0;

  function automatic void frame_geometry(output longint c, output longint lead,
                                         output longint total);
    longint r;
    c = cols_reg;
    r = rows_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    lead = 2 * c + 2;
    total = r * c;
  endfunction

  function automatic void conv_predict(input logic signed [PIX_W-1:0] px);
    longint c, lead, total, n, p, back, acc;
    int kr, kc;
    logic signed [PIX_W-1:0] w;
    out_item_t e;
    frame_geometry(c, lead, total);
    line_wr = (line_wr + 1) % LINE_DEPTH;
    line_buf[line_wr] = px;
    n = frame_count;
    if (n < lead) begin
      frame_count = n + 1;
      return;
    end
    p = n - lead;
    if (p >= total) begin
      frame_count = 0;
      return;
    end
    acc = 0;
    for (kr = 0; kr < 3; kr++) begin
      for (kc = 0; kc < 3; kc++) begin
        w = taps[kr][PIX_W*kc +: PIX_W];
        back = lead - kr * c - kc;
        acc += longint'(w) * longint'(line_buf[(line_wr + LINE_DEPTH - back) % LINE_DEPTH]);
      end
    end
    e.result = RES_W'(acc * longint'(gain));
    e.idx = IDX_W'(p);
    e.last = (p == total - 1);
    frame_count = (p == total - 1) ? 0 : n + 1;
    conv_results.push_back(e);
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_tap();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    return {rand_tap(), rand_tap(), rand_tap()};
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // accept side: predict on every taken item, check every taken result
  always @(posedge clk) begin : check
    out_item_t want;
    if (!rst) begin
      if (push && !full) begin
        conv_predict(pixel);
        pixels_taken++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (conv_results.size() == 0) begin
          note_error($sformatf("unexpected item: result %0d index %0d last %0b",
                               result, out_index, last));
        end else begin
          want = conv_results.pop_front();
          if (result !== want.result || out_index !== want.idx || last !== want.last) begin
            note_error($sformatf("got result %0d index %0d last %0b, want %0d index %0d last %0b",
                                 result, out_index, last, $signed(want.result),
                                 want.idx, want.last));
          end
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sender
  int unsigned drv_seen = 0;
  int unsigned drv_gap = 0;
  bit drv_quiet = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || pixels_taken != drv_seen) begin
      if (push) begin
        drv_seen = pixels_taken;
        drv_gap = pick_gap(drv_quiet);
        if ($urandom_range(0, 199) == 0) drv_quiet = !drv_quiet;
      end
      if (drv_gap > 0) begin
        drv_gap--;
        push <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        push <= 1'b1;
        pixel <= pending_pixels.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  int unsigned rcv_seen = 0;
  int unsigned rcv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned holds_taken = 0;
  bit rcv_quiet = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_asks != holds_taken) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      if (results_seen != rcv_seen) begin
        rcv_seen = results_seen;
        rcv_gap = pick_gap(rcv_quiet);
        if ($urandom_range(0, 149) == 0) rcv_quiet = !rcv_quiet;
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [COEF_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    case (a)
      REG_COLS: cols_reg = d[DIM_W-1:0];
      REG_ROWS: rows_reg = d[DIM_W-1:0];
      REG_COEF_TOP: taps[0] = d;
      REG_COEF_MID: taps[1] = d;
      REG_COEF_BOTTOM: taps[2] = d;
      REG_SCALE: gain = d[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (4) @(negedge clk);
  endtask

  task automatic settle();
    do @(posedge clk); while (pending_pixels.size() != 0 || push || conv_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned budget, seg, n_items, r;
    longint c, lead, total, to_end;
    cols_reg = DIM_W'(1024);
    rows_reg = DIM_W'(1024);
    taps[0] = '0;
    taps[1] = '0;
    taps[2] = '0;
    gain = 16'sd1;
    foreach (line_buf[i]) line_buf[i] = '0;
    line_wr = 0;
    frame_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // single-window frames at the signed extremes
    write_reg(REG_COLS, '0);
    write_reg(REG_ROWS, '0);
    write_reg(REG_COEF_TOP, {3{16'h8000}});
    write_reg(REG_COEF_MID, {3{16'h8000}});
    write_reg(REG_COEF_BOTTOM, {3{16'h8000}});
    write_reg(REG_SCALE, COEF_W'(16'h8000));
    write_reg(REG_SPARE_B, '1);
    end_writes();
    repeat (5) pending_pixels.push_back(16'h8000);
    repeat (5) pending_pixels.push_back(16'h7FFF);
    settle();

    write_reg(REG_COLS, COEF_W'(2));
    write_reg(REG_ROWS, COEF_W'(2));
    write_reg(REG_SCALE, '0);
    write_reg(REG_SPARE_A, rand_coef());
    end_writes();
    repeat (7) pending_pixels.push_back(rand_pixel());
    settle();

    // narrower stride mid-frame puts the counter past the end of the frame
    write_reg(REG_COLS, COEF_W'(1));
    write_reg(REG_SCALE, COEF_W'(1));
    write_reg(REG_COEF_TOP, rand_coef());
    end_writes();
    repeat (7) pending_pixels.push_back(rand_pixel());
    settle();

    // wide stride, a few windows only
    write_reg(REG_COLS, COEF_W'(WIDE_COLS));
    write_reg(REG_ROWS, COEF_W'(1));
    write_reg(REG_COEF_TOP, rand_coef());
    write_reg(REG_COEF_MID, rand_coef());
    write_reg(REG_COEF_BOTTOM, rand_coef());
    write_reg(REG_SCALE, COEF_W'(rand_tap()));
    end_writes();
    repeat (2 * WIDE_COLS + 14) pending_pixels.push_back(rand_pixel());
    settle();

    // tallest frame while the receiver holds off
    write_reg(REG_COLS, COEF_W'(1));
    write_reg(REG_ROWS, COEF_W'(11'h7FF));
    end_writes();
    repeat (60) pending_pixels.push_back(rand_pixel());
    hold_asks++;
    settle();

    budget = pixels_taken;
    seg = 0;
    while (budget < TOTAL_ITEMS) begin
      if ($urandom_range(0, 1) != 0) begin
        r = $urandom_range(0, 19);
        write_reg(REG_COLS, COEF_W'((r == 0) ? 0 : (r == 1) ? $urandom_range(13, 64)
                                                            : $urandom_range(1, 12)));
      end
      if ($urandom_range(0, 1) != 0) begin
        r = $urandom_range(0, 19);
        write_reg(REG_ROWS, COEF_W'((r == 0) ? 0 : (r == 1) ? 1024 : (r == 2) ? 2047
                                    : (r == 3) ? $urandom_range(9, 30) : $urandom_range(1, 8)));
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_COEF_TOP, rand_coef());
      if ($urandom_range(0, 2) == 0) write_reg(REG_COEF_MID, rand_coef());
      if ($urandom_range(0, 2) == 0) write_reg(REG_COEF_BOTTOM, rand_coef());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SCALE, COEF_W'(rand_tap()));
      end_writes();

      frame_geometry(c, lead, total);
      if (frame_count > lead + total - 1) to_end = lead + total + 1;
      else to_end = lead + total - frame_count;
      if ($urandom_range(0, 9) < 7) begin
        n_items = 32'(to_end + longint'($urandom_range(0, 2)) * (lead + total));
      end else begin
        n_items = $urandom_range(1, 30);
      end
      if (n_items > 200) n_items = $urandom_range(20, 200);
      repeat (n_items) pending_pixels.push_back(rand_pixel());
      if (seg % 15 == 7) hold_asks++;
      budget += n_items;
      seg++;
      settle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
